// ===== rtl/tube_digit_spin_animator_top_macros.svh =====
// Assertion macros for the tube digit spin animator checker.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef TUBE_DIGIT_SPIN_ANIMATOR_TOP_MACROS_SVH
`define TUBE_DIGIT_SPIN_ANIMATOR_TOP_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is active.
`define TDSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form, built on the macro above.
`define TDSA_ASSERT_IMP(label, ante, cons, msg) \
	`TDSA_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/tdsa_pkg.sv =====
// Shared types and constants of the tube digit spin animator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tdsa_pkg;

	localparam int NUM_TUBES = 4;
	localparam int TUBE_IDX_W = 2;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W = 5;
	localparam int NUM_DIGITS = 10;

	localparam logic REG_STEP_MS = 1'b0;
	localparam logic REG_MIN_STEPS = 1'b1;

	localparam logic [15:0] STEP_MS_RST = 16'd50;
	localparam logic [15:0] MIN_STEPS_RST = 16'd80;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic load;
		logic seed_step;
		logic div_step;
		logic finish;
		logic [TUBE_IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic running;
	} sts_t;

	function automatic digit_t tens_of(input logic [5:0] v);
		digit_t t;
		t = 4'd0;
		for (int i = 1; i <= 6; i++) begin
			if (v >= 6'(10 * i)) begin
				t = 4'(i);
			end
		end
		return t;
	endfunction

	function automatic digit_t units_of(input logic [5:0] v);
		logic [5:0] r;
		r = v - (6'(tens_of(v)) * 6'd10);
		return r[3:0];
	endfunction

endpackage

// ===== rtl/tdsa_ctrl.sv =====
// Controller of the tube digit spin animator: sequences seeding, division and result write.
// Depends on tdsa_pkg.
`timescale 1ns / 1ps

module tdsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  tdsa_pkg::sts_t     sts,
	output tdsa_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEED = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [tdsa_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;
	logic take;
	logic fin_ok;

	assign item_stall = (state_q != ST_IDLE);
	assign take = item_valid && (state_q == ST_IDLE);
	assign fin_ok = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.idx = cnt_q[tdsa_pkg::TUBE_IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.load = 1'b1;
					cnt_d = '0;
					if (sts.mode == tdsa_pkg::MODE_UPDATE) begin
						state_d = sts.running ? ST_DIV : ST_FIN;
					end else begin
						state_d = sts.running ? ST_FIN : ST_SEED;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
				cnt_d = cnt_q + tdsa_pkg::CNT_W'(1);
				if (cnt_q == tdsa_pkg::CNT_W'(tdsa_pkg::NUM_TUBES - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + tdsa_pkg::CNT_W'(1);
				if (cnt_q == tdsa_pkg::CNT_W'(tdsa_pkg::DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_ok) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/tdsa_dp.sv =====
// Datapath of the tube digit spin animator: registers, seed search, divider and result word.
// Depends on tdsa_pkg.
`timescale 1ns / 1ps

module tdsa_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tdsa_pkg::cmd_t         cmd,
	output tdsa_pkg::sts_t         sts,
	input  logic                   cfg_we,
	input  logic                   cfg_sel,
	input  logic [15:0]            cfg_wdata,
	output logic [15:0]            step_ms,
	output logic [15:0]            min_steps,
	input  logic                   mode,
	input  logic [4:0]             start_hour,
	input  logic [5:0]             start_minute,
	input  logic [4:0]             target_hour,
	input  logic [5:0]             target_minute,
	input  logic [31:0]            now_ms,
	output tdsa_pkg::digit_t       tube0_digit,
	output tdsa_pkg::digit_t       tube1_digit,
	output tdsa_pkg::digit_t       tube2_digit,
	output tdsa_pkg::digit_t       tube3_digit,
	output logic                   running,
	output logic                   refreshed,
	output logic                   accepted
);

	logic [15:0] step_ms_q, min_steps_q;
	logic run_q;
	logic [tdsa_pkg::NUM_TUBES-1:0] spin_q;
	logic [31:0] stamp_q;
	tdsa_pkg::digit_t seed_q [tdsa_pkg::NUM_TUBES];
	tdsa_pkg::digit_t goal_q [tdsa_pkg::NUM_TUBES];

	logic mode_q;
	logic [31:0] now_q;
	tdsa_pkg::digit_t raw_q [tdsa_pkg::NUM_TUBES];
	tdsa_pkg::digit_t tgt_q [tdsa_pkg::NUM_TUBES];
	logic [tdsa_pkg::NUM_DIGITS-1:0] used_q;

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	tdsa_pkg::digit_t ph_q;

	tdsa_pkg::digit_t shown_q [tdsa_pkg::NUM_TUBES];
	logic running_q, refreshed_q, accepted_q;

	logic [15:0] divisor;
	logic [16:0] shifted;
	logic [17:0] diff;
	logic qbit;
	logic [4:0] ph_twice;

	tdsa_pkg::digit_t seed_pick;
	logic [4:0] cand;

	tdsa_pkg::digit_t shown [tdsa_pkg::NUM_TUBES];
	logic [tdsa_pkg::NUM_TUBES-1:0] spin_next;
	logic steps_ok;
	logic [4:0] sum;

	assign step_ms = step_ms_q;
	assign min_steps = min_steps_q;
	assign sts.mode = mode;
	assign sts.running = run_q;

	assign divisor = (step_ms_q == 16'd0) ? 16'd1 : step_ms_q;
	assign shifted = {rem_q, quo_q[31]};
	assign diff = {1'b0, shifted} - {2'b00, divisor};
	assign qbit = !diff[17];
	assign ph_twice = {ph_q, 1'b0} + {4'd0, qbit};

	always_comb begin
		seed_pick = raw_q[cmd.idx];
		cand = '0;
		for (int k = tdsa_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
			cand = {1'b0, raw_q[cmd.idx]} + 5'(k);
			if (cand >= 5'(tdsa_pkg::NUM_DIGITS)) begin
				cand = cand - 5'(tdsa_pkg::NUM_DIGITS);
			end
			if (!used_q[cand[3:0]]) begin
				seed_pick = cand[3:0];
			end
		end
	end

	always_comb begin
		steps_ok = (quo_q >= {16'd0, min_steps_q});
		sum = '0;
		for (int i = 0; i < tdsa_pkg::NUM_TUBES; i++) begin
			sum = {1'b0, seed_q[i]} + {1'b0, ph_q};
			if (sum >= 5'(tdsa_pkg::NUM_DIGITS)) begin
				sum = sum - 5'(tdsa_pkg::NUM_DIGITS);
			end
			shown[i] = spin_q[i] ? sum[3:0] : goal_q[i];
			spin_next[i] = spin_q[i] && !((sum[3:0] == goal_q[i]) && steps_ok);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ms_q <= tdsa_pkg::STEP_MS_RST;
			min_steps_q <= tdsa_pkg::MIN_STEPS_RST;
			run_q <= 1'b0;
			spin_q <= '0;
		end else begin
			if (cfg_we && (cfg_sel == tdsa_pkg::REG_STEP_MS)) begin
				step_ms_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_sel == tdsa_pkg::REG_MIN_STEPS)) begin
				min_steps_q <= cfg_wdata;
			end
			if (cmd.finish && run_q && (mode_q == tdsa_pkg::MODE_UPDATE)) begin
				spin_q <= spin_next;
				run_q <= |spin_next;
			end else if (cmd.finish && !run_q && (mode_q == tdsa_pkg::MODE_START)) begin
				spin_q <= '1;
				run_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			now_q <= now_ms;
			raw_q[0] <= tdsa_pkg::tens_of({1'b0, start_hour});
			raw_q[1] <= tdsa_pkg::units_of({1'b0, start_hour});
			raw_q[2] <= tdsa_pkg::tens_of(start_minute);
			raw_q[3] <= tdsa_pkg::units_of(start_minute);
			tgt_q[0] <= tdsa_pkg::tens_of({1'b0, target_hour});
			tgt_q[1] <= tdsa_pkg::units_of({1'b0, target_hour});
			tgt_q[2] <= tdsa_pkg::tens_of(target_minute);
			tgt_q[3] <= tdsa_pkg::units_of(target_minute);
			used_q <= '0;
			quo_q <= now_ms - stamp_q;
			rem_q <= '0;
			ph_q <= '0;
		end
		if (cmd.seed_step) begin
			seed_q[cmd.idx] <= seed_pick;
			used_q[seed_pick] <= 1'b1;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[30:0], qbit};
			ph_q <= (ph_twice >= 5'(tdsa_pkg::NUM_DIGITS)) ?
				4'(ph_twice - 5'(tdsa_pkg::NUM_DIGITS)) : ph_twice[3:0];
		end
		if (cmd.finish) begin
			for (int i = 0; i < tdsa_pkg::NUM_TUBES; i++) begin
				shown_q[i] <= '0;
			end
			refreshed_q <= 1'b0;
			accepted_q <= 1'b0;
			running_q <= run_q;
			if (mode_q == tdsa_pkg::MODE_START) begin
				if (!run_q) begin
					stamp_q <= now_q;
					for (int i = 0; i < tdsa_pkg::NUM_TUBES; i++) begin
						goal_q[i] <= tgt_q[i];
					end
					accepted_q <= 1'b1;
					running_q <= 1'b1;
				end
			end else if (run_q) begin
				for (int i = 0; i < tdsa_pkg::NUM_TUBES; i++) begin
					shown_q[i] <= shown[i];
				end
				refreshed_q <= 1'b1;
				running_q <= |spin_next;
			end
		end
	end

	assign tube0_digit = shown_q[0];
	assign tube1_digit = shown_q[1];
	assign tube2_digit = shown_q[2];
	assign tube3_digit = shown_q[3];
	assign running = running_q;
	assign refreshed = refreshed_q;
	assign accepted = accepted_q;

endmodule

// ===== rtl/tube_digit_spin_animator_top.sv =====
// Top level of the tube digit spin animator: APB register port, controller and datapath.
// Depends on tdsa_pkg, tdsa_ctrl and tdsa_dp.
// A start word that seeds an animation passes the seed states, an update word while
// spinning passes the restoring divide, and other words go straight to the finish state.
// Words are taken only while idle; a finished result may wait in the output register.
// Reset idles the controller, stops any animation and restores step_ms to 50 and min_steps to 80.
`timescale 1ns / 1ps

module tube_digit_spin_animator_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              mode,
	input  logic [4:0]        start_hour,
	input  logic [5:0]        start_minute,
	input  logic [4:0]        target_hour,
	input  logic [5:0]        target_minute,
	input  logic [31:0]       now_ms,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [3:0]        tube0_digit,
	output logic [3:0]        tube1_digit,
	output logic [3:0]        tube2_digit,
	output logic [3:0]        tube3_digit,
	output logic              running,
	output logic              refreshed,
	output logic              accepted
);

	tdsa_pkg::cmd_t cmd;
	tdsa_pkg::sts_t sts;
	logic cfg_we;
	logic [15:0] step_ms, min_steps;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == tdsa_pkg::REG_MIN_STEPS) ? {16'd0, min_steps} : {16'd0, step_ms};

	tdsa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	tdsa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_sel       (paddr[2]),
		.cfg_wdata     (pwdata[15:0]),
		.step_ms       (step_ms),
		.min_steps     (min_steps),
		.mode          (mode),
		.start_hour    (start_hour),
		.start_minute  (start_minute),
		.target_hour   (target_hour),
		.target_minute (target_minute),
		.now_ms        (now_ms),
		.tube0_digit   (tube0_digit),
		.tube1_digit   (tube1_digit),
		.tube2_digit   (tube2_digit),
		.tube3_digit   (tube3_digit),
		.running       (running),
		.refreshed     (refreshed),
		.accepted      (accepted)
	);

endmodule

// ===== rtl/tdsa_chk.sv =====
// Port-level checker for the tube digit spin animator, bound to the top level.
// Depends on tube_digit_spin_animator_top_macros.svh.
`timescale 1ns / 1ps
`include "tube_digit_spin_animator_top_macros.svh"

module tdsa_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [3:0] tube0_digit,
	input logic [3:0] tube1_digit,
	input logic [3:0] tube2_digit,
	input logic [3:0] tube3_digit,
	input logic       running,
	input logic       refreshed,
	input logic       accepted
);

	`TDSA_ASSERT(a_result_hold,
		result_valid && result_stall |=> result_valid && $stable(tube0_digit) && $stable(running),
		"stalled result word changed")
	`TDSA_ASSERT(a_busy_after_take,
		item_valid && !item_stall |=> item_stall,
		"second word taken while busy")
	`TDSA_ASSERT_IMP(a_flags_excl,
		result_valid, !(accepted && refreshed),
		"accepted and refreshed both set")
	`TDSA_ASSERT_IMP(a_accept_runs,
		result_valid && accepted, running,
		"new animation not running")
	`TDSA_ASSERT_IMP(a_blank_digits,
		result_valid && !refreshed,
		(tube0_digit == 4'd0) && (tube1_digit == 4'd0) && (tube2_digit == 4'd0)
			&& (tube3_digit == 4'd0),
		"digits shown without refresh")

endmodule

bind tube_digit_spin_animator_top tdsa_chk u_chk (.*);

// ===== verif/tb_tube_digit_spin_animator_top.sv =====
// Self-checking testbench for the tube digit spin animator top level.
// It drives start and update words, predicts every result word in its own model and compares
// them field by field; it depends on tdsa_pkg and tube_digit_spin_animator_top.
`timescale 1ns / 1ps

module tb_tube_digit_spin_animator_top;

	localparam int QUIET_LIMIT = 3000;
	localparam logic [2:0] ADDR_STEP_MS = {tdsa_pkg::REG_STEP_MS, 2'b00};
	localparam logic [2:0] ADDR_MIN_STEPS = {tdsa_pkg::REG_MIN_STEPS, 2'b00};

	typedef struct packed {
		logic mode;
		logic [4:0] start_hour;
		logic [5:0] start_minute;
		logic [4:0] target_hour;
		logic [5:0] target_minute;
		logic [31:0] now_ms;
	} clock_word_t;

	typedef struct packed {
		tdsa_pkg::digit_t [3:0] digit;
		logic running;
		logic refreshed;
		logic accepted;
	} tube_frame_t;

	typedef struct packed {
		logic [15:0] step_ms;
		logic [15:0] min_steps;
		logic active;
		logic [31:0] stamp;
		tdsa_pkg::digit_t [3:0] seed;
		tdsa_pkg::digit_t [3:0] goal;
		logic [3:0] spinning;
	} spin_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	clock_word_t offered = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [3:0] tube0_digit, tube1_digit, tube2_digit, tube3_digit;
	logic running, refreshed, accepted;

	clock_word_t words_to_send[$];
	tube_frame_t frames_due[$];
	spin_state_t gen_state;
	spin_state_t chk_state;
	int unsigned words_sent = 0;
	int unsigned words_taken = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	int idle_pct = 10;
	int rx_hold = 0;
	logic [31:0] plan_steps = '0;

	tube_digit_spin_animator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.mode(offered.mode),
		.start_hour(offered.start_hour),
		.start_minute(offered.start_minute),
		.target_hour(offered.target_hour),
		.target_minute(offered.target_minute),
		.now_ms(offered.now_ms),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.tube0_digit(tube0_digit),
		.tube1_digit(tube1_digit),
		.tube2_digit(tube2_digit),
		.tube3_digit(tube3_digit),
		.running(running),
		.refreshed(refreshed),
		.accepted(accepted)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic spin_state_t idle_animation();
		spin_state_t s;
		s = '0;
		s.step_ms = tdsa_pkg::STEP_MS_RST;
		s.min_steps = tdsa_pkg::MIN_STEPS_RST;
		return s;
	endfunction

	// Applies one word to an animation state and returns the frame it produces.
	function automatic tube_frame_t spin_frame(inout spin_state_t s, input clock_word_t w);
		tube_frame_t f;
		tdsa_pkg::digit_t raw [4];
		logic [9:0] used;
		logic placed;
		int unsigned c;
		logic [31:0] div;
		logic [31:0] steps;
		logic any_spin;
		f = '0;
		if (w.mode == tdsa_pkg::MODE_START) begin
			if (!s.active) begin
				raw[0] = tdsa_pkg::digit_t'(w.start_hour / 10);
				raw[1] = tdsa_pkg::digit_t'(w.start_hour % 10);
				raw[2] = tdsa_pkg::digit_t'(w.start_minute / 10);
				raw[3] = tdsa_pkg::digit_t'(w.start_minute % 10);
				s.goal[0] = tdsa_pkg::digit_t'(w.target_hour / 10);
				s.goal[1] = tdsa_pkg::digit_t'(w.target_hour % 10);
				s.goal[2] = tdsa_pkg::digit_t'(w.target_minute / 10);
				s.goal[3] = tdsa_pkg::digit_t'(w.target_minute % 10);
				used = '0;
				for (int i = 0; i < 4; i++) begin
					placed = 1'b0;
					for (int k = 0; k < 10; k++) begin
						c = (int'(raw[i]) + k) % 10;
						if (!placed && !used[c]) begin
							s.seed[i] = tdsa_pkg::digit_t'(c);
							used[c] = 1'b1;
							placed = 1'b1;
						end
					end
				end
				s.spinning = 4'hF;
				s.active = 1'b1;
				s.stamp = w.now_ms;
				f.accepted = 1'b1;
			end
		end else if (s.active) begin
			div = (s.step_ms == 16'd0) ? 32'd1 : {16'd0, s.step_ms};
			steps = (w.now_ms - s.stamp) / div;
			any_spin = 1'b0;
			for (int i = 0; i < 4; i++) begin
				if (!s.spinning[i]) begin
					f.digit[i] = s.goal[i];
				end else begin
					f.digit[i] = tdsa_pkg::digit_t'((int'(s.seed[i]) + int'(steps % 10)) % 10);
					if (f.digit[i] == s.goal[i] && steps >= {16'd0, s.min_steps}) begin
						s.spinning[i] = 1'b0;
					end
					if (s.spinning[i]) begin
						any_spin = 1'b1;
					end
				end
			end
			f.refreshed = 1'b1;
			if (!any_spin) begin
				s.active = 1'b0;
			end
		end
		f.running = s.active;
		return f;
	endfunction

	function automatic clock_word_t random_start();
		clock_word_t w;
		w.mode = tdsa_pkg::MODE_START;
		w.start_hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 23));
		w.start_minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 59));
		w.target_hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 23));
		w.target_minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 59));
		w.now_ms = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000)
			: $urandom;
		return w;
	endfunction

	task automatic queue_word(input clock_word_t w);
		words_to_send.push_back(w);
		void'(spin_frame(gen_state, w));
	endtask

	task automatic queue_start(input int sh, input int sm, input int th, input int tm,
			input logic [31:0] now);
		clock_word_t w;
		w = '0;
		w.mode = tdsa_pkg::MODE_START;
		w.start_hour = 5'(sh);
		w.start_minute = 6'(sm);
		w.target_hour = 5'(th);
		w.target_minute = 6'(tm);
		w.now_ms = now;
		queue_word(w);
	endtask

	task automatic queue_update(input logic [31:0] elapsed);
		clock_word_t w;
		w = '0;
		w.mode = tdsa_pkg::MODE_UPDATE;
		w.now_ms = gen_state.stamp + elapsed;
		queue_word(w);
	endtask

	// Mostly whole animations: a start, then updates whose step count creeps past the
	// minimum so the tubes settle, with stray starts and idle updates mixed in.
	task automatic plan_random(input int count);
		clock_word_t w;
		int made;
		int r;
		longint unsigned div;
		longint unsigned offset;
		made = 0;
		while (made < count) begin
			w = random_start();
			r = $urandom_range(0, 99);
			if (gen_state.active) begin
				if (r >= 4) begin
					w.mode = tdsa_pkg::MODE_UPDATE;
					div = (gen_state.step_ms == 16'd0) ? 1 : gen_state.step_ms;
					r = $urandom_range(0, 99);
					if (gen_state.min_steps > 16'd12 && plan_steps < gen_state.min_steps - 12
							&& r < 30) begin
						plan_steps = gen_state.min_steps - $urandom_range(0, 12);
					end else if (r < 40) begin
						plan_steps = plan_steps + $urandom_range(3, 30);
					end else begin
						plan_steps = plan_steps + $urandom_range(0, 2);
					end
					offset = longint'(plan_steps) * div + $urandom_range(0, 32'(div - 1));
					w.now_ms = gen_state.stamp + offset[31:0];
					if ($urandom_range(0, 49) == 0) begin
						w.now_ms = $urandom;
					end
					made++;
				end
			end else if (r < 15) begin
				w.mode = tdsa_pkg::MODE_UPDATE;
			end else begin
				plan_steps = '0;
				made++;
			end
			queue_word(w);
		end
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_timing(input int step, input int minimum);
		reg_write(ADDR_STEP_MS, 32'(step));
		reg_write(ADDR_MIN_STEPS, 32'(minimum));
		gen_state.step_ms = 16'(step);
		gen_state.min_steps = 16'(minimum);
		chk_state.step_ms = 16'(step);
		chk_state.min_steps = 16'(minimum);
	endtask

	task automatic wait_quiet();
		while (words_to_send.size() != 0 || words_taken != words_sent
				|| frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!item_valid || words_taken == words_sent)) begin
			if (words_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				offered <= words_to_send.pop_front();
				item_valid <= 1'b1;
				words_sent++;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold--;
		end else begin
			result_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		tube_frame_t got;
		tube_frame_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (item_valid && !item_stall) begin
				frames_due.push_back(spin_frame(chk_state, offered));
				words_taken++;
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				got.digit = {tube3_digit, tube2_digit, tube1_digit, tube0_digit};
				got.running = running;
				got.refreshed = refreshed;
				got.accepted = accepted;
				if (frames_due.size() == 0) begin
					$error("result word arrived while none was expected");
					fail_count++;
				end else begin
					want = frames_due.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (got.digit[i] !== want.digit[i]) begin
							$error("tube%0d_digit: expected %0d, got %0d", i,
								want.digit[i], got.digit[i]);
							fail_count++;
						end
					end
					if (got.running !== want.running) begin
						$error("running: expected %0d, got %0d", want.running, got.running);
						fail_count++;
					end
					if (got.refreshed !== want.refreshed) begin
						$error("refreshed: expected %0d, got %0d", want.refreshed,
							got.refreshed);
						fail_count++;
					end
					if (got.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
						fail_count++;
					end
				end
			end
			if (moved || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int phase_step [8];
		int phase_min [8];
		gen_state = idle_animation();
		chk_state = idle_animation();
		phase_step = '{1, 0, 65535, 1, 7, 50, 0, 0};
		phase_min = '{0, 5, 4, 65535, 12, 80, 0, 0};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset timing: 50 ms per step, 80 steps before a tube may settle.
		queue_update(32'd0);
		queue_update(32'hFFFF_FFFF);
		queue_start(0, 0, 23, 59, 32'hFFFF_FF00);
		queue_start(31, 63, 31, 63, 32'd0);
		queue_update(32'd0);
		queue_update(32'd49);
		queue_update(32'd50 * 32'd79);
		for (int k = 0; k < 12; k++) begin
			queue_update(32'd50 * 32'(80 + k));
		end
		queue_update(32'd1_000_000);
		queue_start(31, 63, 31, 63, 32'd0);
		queue_update(32'd50 * 32'd80);
		queue_update(32'd50 * 32'd89);
		queue_start(19, 19, 0, 0, 32'd12345);
		queue_update(32'd50 * 32'd100);
		wait_quiet();

		for (int p = 0; p < 8; p++) begin
			if (p >= 6) begin
				phase_step[p] = $urandom_range(1, 300);
				phase_min[p] = $urandom_range(0, 40);
			end
			set_timing(phase_step[p], phase_min[p]);
			idle_pct = (p == 4) ? 0 : 10;
			plan_random(80);
			if (p == 1) begin
				rx_hold = 300;
			end
			wait_quiet();
			plan_random(75);
			wait_quiet();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && frames_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tdsa_pkg.sv
rtl/tdsa_ctrl.sv
rtl/tdsa_dp.sv
rtl/tube_digit_spin_animator_top.sv
rtl/tdsa_chk.sv
verif/tb_tube_digit_spin_animator_top.sv
